@@ hdl/lcabl_pkg.sv @@
`default_nettype none
package lcabl_pkg;

  localparam int MAX_NODES = 1024;
  localparam int LEVELS    = 11;

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int CNT_W  = 11;
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int JT_W   = NODE_W + 1;
  localparam int JT_AW  = NODE_W + LVL_W;
  localparam int JT_D   = 1 << JT_AW;
  localparam int HW     = (LEVELS > NODE_W) ? LEVELS + 1 : NODE_W + 1;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_BUILD = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  // table entry: top bit marks a jump past the root
  localparam logic [JT_W-1:0] NO_NODE = {1'b1, {NODE_W{1'b0}}};

  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] ancestor;
    logic              bad;
  } res_t;

  function automatic logic [JT_W-1:0] hop(input logic [JT_W-1:0] entry,
                                          input logic [LVL_W-1:0] lvl,
                                          input logic [NODE_W-1:0] v,
                                          input logic [CNT_W-1:0] n);
    logic [JT_W-1:0] r;
    r = entry;
    if (lvl == '0) begin
      if (v == '0) r = '0;
      else if (CNT_W'(entry[NODE_W-1:0]) < n) r = {1'b0, entry[NODE_W-1:0]};
      else r = NO_NODE;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/lcabl_ram.sv @@
`default_nettype none
module lcabl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/lcabl_engine.sv @@
`default_nettype none
module lcabl_engine
  import lcabl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire logic [1:0]        cmd_action,
  input  wire logic [NODE_W-1:0] cmd_node,
  input  wire logic [NODE_W-1:0] cmd_other,
  input  wire logic              cfg_clr,
  input  wire logic [CNT_W-1:0]  nuse,
  output logic                   jt_we,
  output logic [JT_AW-1:0]       jt_waddr,
  output logic [JT_W-1:0]        jt_wdata,
  output logic [JT_AW-1:0]       jt_raddr,
  input  wire logic [JT_W-1:0]   jt_rdata,
  output logic                   dp_we,
  output logic [NODE_W-1:0]      dp_waddr,
  output logic [NODE_W-1:0]      dp_wdata,
  output logic [NODE_W-1:0]      dp_raddr,
  input  wire logic [NODE_W-1:0] dp_rdata,
  output res_t                   res,
  input  wire logic              res_ready
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_BRD  = 5'd1;
  localparam logic [4:0] S_BX   = 5'd2;
  localparam logic [4:0] S_BY   = 5'd3;
  localparam logic [4:0] S_DRD  = 5'd4;
  localparam logic [4:0] S_DCHK = 5'd5;
  localparam logic [4:0] S_QDA  = 5'd6;
  localparam logic [4:0] S_QDB  = 5'd7;
  localparam logic [4:0] S_QL1  = 5'd8;
  localparam logic [4:0] S_QL2  = 5'd9;
  localparam logic [4:0] S_QEQ  = 5'd10;
  localparam logic [4:0] S_QJA  = 5'd11;
  localparam logic [4:0] S_QJB  = 5'd12;
  localparam logic [4:0] S_QJC  = 5'd13;
  localparam logic [4:0] S_QP   = 5'd14;
  localparam logic [4:0] S_QPF  = 5'd15;
  localparam logic [4:0] S_DONE = 5'd16;

  localparam logic [LVL_W-1:0] LVL_TOP  = LVL_W'(LEVELS - 1);
  localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LEVELS - 2);
  localparam logic [HW-1:0]    DSAT     = HW'(MAX_NODES - 1);

  logic [4:0]        state_r, state_nxt;
  logic              built_r, built_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [NODE_W-1:0] v_r, v_nxt;
  logic [NODE_W-1:0] a_r, a_nxt;
  logic [NODE_W-1:0] b_r, b_nxt;
  logic [JT_W-1:0]   ja_r, ja_nxt;
  logic [NODE_W-1:0] da_r, da_nxt;
  logic [HW-1:0]     h_r, h_nxt;
  logic [HW-1:0]     d_r, d_nxt;
  logic [NODE_W-1:0] anc_r, anc_nxt;
  logic              bad_r, bad_nxt;

  logic [JT_W-1:0]   hx;
  logic [HW-1:0]     pow;
  logic              v_last;

  assign cmd_ready    = (state_r == S_IDLE);
  assign res.valid    = (state_r == S_DONE);
  assign res.ancestor = anc_r;
  assign res.bad      = bad_r;
  assign pow          = HW'(1) << lvl_r;
  assign v_last       = (CNT_W'(v_r) + CNT_W'(1)) == nuse;

  always_comb begin
    state_nxt = state_r;
    built_nxt = built_r;
    lvl_nxt   = lvl_r;
    v_nxt     = v_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    ja_nxt    = ja_r;
    da_nxt    = da_r;
    h_nxt     = h_r;
    d_nxt     = d_r;
    anc_nxt   = anc_r;
    bad_nxt   = bad_r;
    jt_we     = 1'b0;
    jt_waddr  = {v_r, lvl_r + LVL_W'(1)};
    jt_wdata  = NO_NODE;
    jt_raddr  = {a_r, lvl_r};
    dp_we     = 1'b0;
    dp_waddr  = v_r;
    dp_wdata  = (d_r > DSAT) ? NODE_W'(MAX_NODES - 1) : d_r[NODE_W-1:0];
    dp_raddr  = a_r;
    hx        = hop(jt_rdata, lvl_r, a_r, nuse);

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd_action)
            ACT_LOAD: begin
              jt_we     = 1'b1;
              jt_waddr  = {cmd_node, LVL_W'(0)};
              jt_wdata  = {1'b0, cmd_other};
              built_nxt = 1'b0;
            end
            ACT_BUILD: begin
              lvl_nxt   = '0;
              v_nxt     = '0;
              state_nxt = S_BRD;
            end
            ACT_QUERY: begin
              a_nxt = cmd_node;
              b_nxt = cmd_other;
              if (!built_r || CNT_W'(cmd_node) >= nuse || CNT_W'(cmd_other) >= nuse) begin
                anc_nxt   = '0;
                bad_nxt   = 1'b1;
                state_nxt = S_DONE;
              end else begin
                dp_raddr  = cmd_node;
                bad_nxt   = 1'b0;
                state_nxt = S_QDA;
              end
            end
            default: ;
          endcase
        end
      end

      // entry(v,i+1) = hop(hop(v,i),i); none via root
      S_BRD: begin
        jt_raddr  = {v_r, lvl_r};
        state_nxt = S_BX;
      end
      S_BX, S_BY: begin
        hx = hop(jt_rdata, lvl_r, (state_r == S_BX) ? v_r : a_r, nuse);
        if (state_r == S_BX && !hx[NODE_W] && hx[NODE_W-1:0] != '0) begin
          a_nxt     = hx[NODE_W-1:0];
          jt_raddr  = {hx[NODE_W-1:0], lvl_r};
          state_nxt = S_BY;
        end else begin
          jt_we    = 1'b1;
          jt_wdata = (state_r == S_BX) ? NO_NODE : hx;
          if (v_last) begin
            v_nxt = '0;
            if (lvl_r == LVL_LAST) begin
              a_nxt     = '0;
              d_nxt     = '0;
              lvl_nxt   = LVL_TOP;
              state_nxt = S_DRD;
            end else begin
              lvl_nxt   = lvl_r + LVL_W'(1);
              state_nxt = S_BRD;
            end
          end else begin
            v_nxt     = v_r + NODE_W'(1);
            state_nxt = S_BRD;
          end
        end
      end

      // depth: greedy climb from the top level down
      S_DRD, S_DCHK: begin
        logic fin;
        fin = 1'b0;
        if (state_r == S_DRD) begin
          if (a_r == '0) fin = 1'b1;
          else state_nxt = S_DCHK;
        end else begin
          if (!hx[NODE_W]) begin
            a_nxt = hx[NODE_W-1:0];
            d_nxt = d_r + pow;
            dp_wdata = ((d_r + pow) > DSAT) ? NODE_W'(MAX_NODES - 1)
                                            : NODE_W'(d_r + pow);
          end
          if (lvl_r == '0) fin = 1'b1;
          else begin
            lvl_nxt   = lvl_r - LVL_W'(1);
            state_nxt = S_DRD;
          end
        end
        if (fin) begin
          dp_we   = 1'b1;
          lvl_nxt = LVL_TOP;
          d_nxt   = '0;
          if (v_last) begin
            built_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            v_nxt     = v_r + NODE_W'(1);
            a_nxt     = v_r + NODE_W'(1);
            state_nxt = S_DRD;
          end
        end
      end

      S_QDA: begin
        da_nxt    = dp_rdata;
        dp_raddr  = b_r;
        state_nxt = S_QDB;
      end
      S_QDB: begin
        if (da_r < dp_rdata) begin
          a_nxt = b_r;
          b_nxt = a_r;
          h_nxt = HW'(dp_rdata - da_r);
        end else begin
          h_nxt = HW'(da_r - dp_rdata);
        end
        lvl_nxt   = LVL_TOP;
        state_nxt = S_QL1;
      end
      S_QL1: begin
        if (pow <= h_r) begin
          h_nxt     = h_r - pow;
          state_nxt = S_QL2;
        end else if (lvl_r == '0) begin
          state_nxt = S_QEQ;
        end else begin
          lvl_nxt = lvl_r - LVL_W'(1);
        end
      end
      S_QL2: begin
        if (!hx[NODE_W]) a_nxt = hx[NODE_W-1:0];
        if (lvl_r == '0) state_nxt = S_QEQ;
        else begin
          lvl_nxt   = lvl_r - LVL_W'(1);
          state_nxt = S_QL1;
        end
      end
      S_QEQ: begin
        if (a_r == b_r) begin
          anc_nxt   = a_r;
          state_nxt = S_DONE;
        end else begin
          lvl_nxt   = LVL_TOP;
          state_nxt = S_QJA;
        end
      end
      S_QJA: state_nxt = S_QJB;
      S_QJB: begin
        ja_nxt    = hx;
        jt_raddr  = {b_r, lvl_r};
        state_nxt = S_QJC;
      end
      S_QJC: begin
        hx = hop(jt_rdata, lvl_r, b_r, nuse);
        if (ja_r != hx && !ja_r[NODE_W] && !hx[NODE_W]) begin
          a_nxt = ja_r[NODE_W-1:0];
          b_nxt = hx[NODE_W-1:0];
        end
        if (lvl_r == '0) state_nxt = S_QP;
        else begin
          lvl_nxt   = lvl_r - LVL_W'(1);
          state_nxt = S_QJA;
        end
      end
      S_QP: state_nxt = S_QPF;
      S_QPF: begin
        anc_nxt   = hx[NODE_W] ? '0 : hx[NODE_W-1:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_clr) built_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      built_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      built_r <= built_nxt;
    end
    lvl_r <= lvl_nxt;
    v_r   <= v_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    ja_r  <= ja_nxt;
    da_r  <= da_nxt;
    h_r   <= h_nxt;
    d_r   <= d_nxt;
    anc_r <= anc_nxt;
    bad_r <= bad_nxt;
  end

endmodule
`default_nettype wire

@@ hdl/lca_binary_lifting.sv @@
// channel | direction | tdata                                 | tuser
// in_     | slave     | [9:0] node, [19:10] other_node        | [1:0] action
// out_    | master    | [9:0] ancestor                        | [0] bad_query
// cfg_    | slave     | [10:0] node_count                     | -
// a load is written straight into the table; a build fills each level node by node,
// with an extra table read when the first hop lands on a node other than the root,
// then climbs from the top level down for each node's depth; a query's time grows
// with the set bits of the depth gap and with a pass over every level when the
// lifted nodes differ, set by the single read port of the jump table; a bad query
// goes straight to the result.
// rst_n is synchronous; the table and depth memories are not cleared.
// the result sits in an output register, so the next beat is taken while it waits.
`default_nettype none
module lca_binary_lifting
  import lcabl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // node, other_node
  input  wire logic [1:0]  in_tuser,   // action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // ancestor
  output logic             out_tuser,  // bad_query
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data    // node_count
);

  logic [CNT_W-1:0]  node_count_r, node_count_nxt;
  logic [CNT_W-1:0]  nuse;
  logic              out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0] out_anc_r;
  logic              out_bad_r;
  logic              res_ready;
  res_t              res;

  logic              jt_we;
  logic [JT_AW-1:0]  jt_waddr, jt_raddr;
  logic [JT_W-1:0]   jt_wdata, jt_rdata;
  logic              dp_we;
  logic [NODE_W-1:0] dp_waddr, dp_wdata, dp_raddr, dp_rdata;

  assign cfg_ready      = 1'b1;
  assign node_count_nxt = cfg_valid ? cfg_data[CNT_W-1:0] : node_count_r;
  assign nuse = (node_count_r == '0) ? CNT_W'(1) :
                (node_count_r > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_r;

  assign res_ready     = !out_valid_r || out_tready;
  assign out_valid_nxt = res.valid ? 1'b1 : (out_valid_r && !out_tready);
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = 16'(out_anc_r);
  assign out_tuser     = out_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CNT_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      node_count_r <= node_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    if (res.valid && res_ready) begin
      out_anc_r <= res.ancestor;
      out_bad_r <= res.bad;
    end
  end

  lcabl_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (in_tvalid),
    .cmd_ready  (in_tready),
    .cmd_action (in_tuser),
    .cmd_node   (in_tdata[NODE_W-1:0]),
    .cmd_other  (in_tdata[2*NODE_W-1:NODE_W]),
    .cfg_clr    (cfg_valid),
    .nuse       (nuse),
    .jt_we      (jt_we),
    .jt_waddr   (jt_waddr),
    .jt_wdata   (jt_wdata),
    .jt_raddr   (jt_raddr),
    .jt_rdata   (jt_rdata),
    .dp_we      (dp_we),
    .dp_waddr   (dp_waddr),
    .dp_wdata   (dp_wdata),
    .dp_raddr   (dp_raddr),
    .dp_rdata   (dp_rdata),
    .res        (res),
    .res_ready  (res_ready)
  );

  lcabl_ram #(.WIDTH(JT_W), .DEPTH(JT_D)) u_jump (
    .clk   (clk),
    .we    (jt_we),
    .waddr (jt_waddr),
    .wdata (jt_wdata),
    .raddr (jt_raddr),
    .rdata (jt_rdata)
  );

  lcabl_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_depth (
    .clk   (clk),
    .we    (dp_we),
    .waddr (dp_waddr),
    .wdata (dp_wdata),
    .raddr (dp_raddr),
    .rdata (dp_rdata)
  );

endmodule
`default_nettype wire

@@ tb/lca_binary_lifting_tb.sv @@
`timescale 1ns / 1ps
module lca_binary_lifting_tb;
  import lcabl_pkg::*;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor;
    logic              bad;
  } lca_res_t;

  typedef struct {
    row_kind_e         kind;
    logic [1:0]        act;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    bit                typed;
    logic [NODE_W-1:0] anc;
    logic              bad;
  } row_t;

  localparam logic [1:0] ACT_NONE = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [23:0]       in_tdata = '0;
  logic [1:0]        in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;
  logic              out_tuser;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [15:0]       cfg_data = '0;

  // shadow copy of the block state
  logic [JT_W-1:0]   lift_tab [MAX_NODES][LEVELS];
  logic [NODE_W-1:0] depth_tab [MAX_NODES];
  bit                tab_ready;
  logic [CNT_W-1:0]  count_reg;

  lca_res_t          lca_expected [$];
  int                errors = 0;
  int                items_sent = 0;
  int                queries_sent = 0;
  int                results_seen = 0;
  int                builds_sent = 0;
  bit                calm = 1'b0;

  always #5 clk = ~clk;

  lca_binary_lifting i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  function automatic int unsigned live_nodes();
    int unsigned n;
    n = count_reg;
    if (n == 0) n = 1;
    if (n > MAX_NODES) n = MAX_NODES;
    return n;
  endfunction

  function automatic logic [JT_W-1:0] step_up(int unsigned v, int unsigned lvl,
                                              int unsigned n);
    logic [JT_W-1:0] p;
    if (v >= n || lvl >= LEVELS) return NO_NODE;
    if (lvl == 0) begin
      if (v == 0) return '0;
      p = lift_tab[v][0];
      return (p < n) ? p : NO_NODE;
    end
    return lift_tab[v][lvl];
  endfunction

  function automatic void build_lift_tab();
    int unsigned n;
    logic [JT_W-1:0] x;
    logic [JT_W-1:0] y;
    int unsigned d;
    n = live_nodes();
    for (int i = 0; i + 1 < LEVELS; i++) begin
      for (int v = 0; v < n; v++) begin
        x = step_up(v, i, n);
        y = (x == NO_NODE || x == 0) ? NO_NODE : step_up(x, i, n);
        lift_tab[v][i+1] = y;
      end
    end
    for (int v = 0; v < n; v++) begin
      x = v;
      d = 0;
      for (int k = LEVELS - 1; k >= 0; k--) begin
        if (x == 0) break;
        y = step_up(x, k, n);
        if (y != NO_NODE) begin
          x = y;
          d += 1 << k;
        end
      end
      if (d > MAX_NODES - 1) d = MAX_NODES - 1;
      depth_tab[v] = d;
    end
    tab_ready = 1'b1;
  endfunction

  function automatic logic [NODE_W-1:0] lowest_common(int unsigned a, int unsigned b,
                                                      int unsigned n);
    int unsigned t, height;
    logic [JT_W-1:0] y, ja, jb;
    if (depth_tab[a] < depth_tab[b]) begin
      t = a; a = b; b = t;
    end
    height = depth_tab[a] - depth_tab[b];
    for (int k = LEVELS - 1; k >= 0; k--) begin
      if ((1 << k) <= height) begin
        height -= 1 << k;
        y = step_up(a, k, n);
        if (y != NO_NODE) a = y;
      end
    end
    if (a == b) return a;
    for (int k = LEVELS - 1; k >= 0; k--) begin
      ja = step_up(a, k, n);
      jb = step_up(b, k, n);
      if (ja != jb && ja != NO_NODE && jb != NO_NODE) begin
        a = ja;
        b = jb;
      end
    end
    y = step_up(a, 0, n);
    return (y == NO_NODE) ? '0 : y[NODE_W-1:0];
  endfunction

  // updates the shadow state; returns 1 when the beat yields a result
  function automatic bit predict_beat(logic [1:0] act, logic [NODE_W-1:0] a,
                                      logic [NODE_W-1:0] b, output lca_res_t r);
    int unsigned n;
    r = '0;
    case (act)
      ACT_LOAD: begin
        lift_tab[a][0] = {1'b0, b};
        tab_ready = 1'b0;
      end
      ACT_BUILD: build_lift_tab();
      ACT_QUERY: begin
        n = live_nodes();
        if (!tab_ready || a >= n || b >= n) r = '{ancestor: '0, bad: 1'b1};
        else r = '{ancestor: lowest_common(a, b, n), bad: 1'b0};
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic send_beat(logic [1:0] act, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                           bit typed = 0, lca_res_t typed_res = '0);
    lca_res_t r;
    calm = (items_sent >= 700 && items_sent < 900);
    while (!calm && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {4'd0, b, a};
    do @(posedge clk); while (!in_tready);
    if (predict_beat(act, a, b, r)) begin
      lca_expected.insert(lca_expected.size(), typed ? typed_res : r);
      queries_sent++;
    end
    if (act == ACT_BUILD) builds_sent++;
    if (act != ACT_NONE) items_sent++;
  endtask

  task automatic write_count(logic [CNT_W-1:0] value);
    in_tvalid <= 1'b0;
    while (lca_expected.size() != 0) @(posedge clk);
    // the last beat is always a query, so only a short margin is needed
    repeat (100) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= {5'd0, value};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    count_reg = value;
    tab_ready = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (lca_expected.size() == 0) begin
          $error("unexpected result beat: ancestor %0d bad_query %0d",
                 out_tdata[NODE_W-1:0], out_tuser);
          errors++;
        end else begin
          lca_res_t e;
          e = lca_expected.pop_front();
          if (out_tdata[NODE_W-1:0] !== e.ancestor) begin
            $error("ancestor: expected %0d, got %0d", e.ancestor, out_tdata[NODE_W-1:0]);
            errors++;
          end
          if (out_tuser !== e.bad) begin
            $error("bad_query: expected %0d, got %0d", e.bad, out_tuser);
            errors++;
          end
        end
      end
      out_tready <= calm || ($urandom_range(99) >= 35);
    end
  end

  row_t directed [] = '{
    '{ROW_ITEM, ACT_QUERY, 10'd0,    10'd0,    1, 10'd0, 1'b1},
    '{ROW_ITEM, ACT_BUILD, 10'd0,    10'd0,    0, 10'd0, 1'b0},
    '{ROW_ITEM, ACT_QUERY, 10'd0,    10'd0,    1, 10'd0, 1'b0},
    '{ROW_ITEM, ACT_QUERY, 10'd1023, 10'd1023, 1, 10'd0, 1'b1},
    '{ROW_ITEM, ACT_LOAD,  10'd0,    10'd1023, 0, 10'd0, 1'b0},
    '{ROW_ITEM, ACT_QUERY, 10'd0,    10'd0,    1, 10'd0, 1'b1},
    '{ROW_ITEM, ACT_NONE,  10'd1023, 10'd1023, 0, 10'd0, 1'b0},
    '{ROW_ITEM, ACT_BUILD, 10'd0,    10'd0,    0, 10'd0, 1'b0},
    '{ROW_ITEM, ACT_QUERY, 10'd0,    10'd0,    1, 10'd0, 1'b0},
    '{ROW_CFG,  ACT_NONE,  10'd0,    10'd0,    0, 10'd0, 1'b0},
    '{ROW_ITEM, ACT_QUERY, 10'd0,    10'd0,    1, 10'd0, 1'b1},
    '{ROW_CFG,  ACT_NONE,  10'd6,    10'd0,    0, 10'd0, 1'b0},
    '{ROW_ITEM, ACT_LOAD,  10'd1,    10'd0,    0, 10'd0, 1'b0},
    '{ROW_ITEM, ACT_LOAD,  10'd2,    10'd1,    0, 10'd0, 1'b0},
    // two nodes pointing at each other, cut off from the root
    '{ROW_ITEM, ACT_LOAD,  10'd3,    10'd4,    0, 10'd0, 1'b0},
    '{ROW_ITEM, ACT_LOAD,  10'd4,    10'd3,    0, 10'd0, 1'b0},
    '{ROW_ITEM, ACT_LOAD,  10'd5,    10'd1023, 0, 10'd0, 1'b0},
    '{ROW_ITEM, ACT_BUILD, 10'd0,    10'd0,    0, 10'd0, 1'b0},
    '{ROW_ITEM, ACT_QUERY, 10'd2,    10'd1,    0, 10'd0, 1'b0},
    '{ROW_ITEM, ACT_QUERY, 10'd3,    10'd4,    0, 10'd0, 1'b0},
    '{ROW_ITEM, ACT_QUERY, 10'd5,    10'd2,    0, 10'd0, 1'b0},
    '{ROW_ITEM, ACT_QUERY, 10'd0,    10'd5,    0, 10'd0, 1'b0},
    '{ROW_ITEM, ACT_QUERY, 10'd6,    10'd0,    1, 10'd0, 1'b1},
    '{ROW_ITEM, ACT_QUERY, 10'd3,    10'd1023, 1, 10'd0, 1'b1},
    '{ROW_ITEM, ACT_LOAD,  10'd1023, 10'd0,    0, 10'd0, 1'b0},
    '{ROW_ITEM, ACT_QUERY, 10'd2,    10'd2,    1, 10'd0, 1'b1}
  };

  task automatic run_tree_phase(logic [CNT_W-1:0] count_value);
    int unsigned n, nq;
    logic [NODE_W-1:0] p, a, b;
    bit chain;
    write_count(count_value);
    n = live_nodes();
    chain = ($urandom_range(99) < 30);
    if ($urandom_range(1)) send_beat(ACT_LOAD, 10'd0, $urandom_range(1023));
    for (int v = 1; v < n; v++) begin
      if ($urandom_range(99) < 85) p = chain ? v - 1 : $urandom_range(v - 1);
      else p = $urandom_range(1023);
      send_beat(ACT_LOAD, v, p);
      if ($urandom_range(99) < 3) send_beat(ACT_NONE, $urandom, $urandom);
    end
    if ($urandom_range(99) < 90) send_beat(ACT_BUILD, $urandom, $urandom);
    nq = $urandom_range(40, 12);
    for (int q = 0; q < nq; q++) begin
      if ($urandom_range(99) < 6) begin
        send_beat(ACT_LOAD, $urandom_range(n - 1), $urandom_range(1023));
        if ($urandom_range(1)) send_beat(ACT_BUILD, $urandom, $urandom);
      end
      if ($urandom_range(99) < 4) send_beat(ACT_NONE, $urandom, $urandom);
      if ($urandom_range(99) < 85) begin
        a = $urandom_range(n - 1);
        b = $urandom_range(n - 1);
      end else begin
        a = $urandom_range(1023);
        b = $urandom_range(1023);
      end
      send_beat(ACT_QUERY, a, b);
    end
  endtask

  initial begin
    row_t rw;
    int phase;
    tab_ready = 1'b0;
    count_reg = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      rw = directed[i];
      if (rw.kind == ROW_CFG) write_count({1'b0, rw.a});
      else send_beat(rw.act, rw.a, rw.b, rw.typed, '{ancestor: rw.anc, bad: rw.bad});
    end

    phase = 0;
    while (items_sent < 1450) begin
      case (phase)
        1:       run_tree_phase(11'd2047);
        3:       run_tree_phase(11'd0);
        4:       run_tree_phase(11'd1);
        5:       run_tree_phase(11'd2);
        default: run_tree_phase($urandom_range(40, 2));
      endcase
      phase++;
    end
    calm = 1'b0;

    in_tvalid <= 1'b0;
    while (lca_expected.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d beats in %0d tree setups: %0d builds, %0d queries, %0d results",
             items_sent, phase + 3, builds_sent, queries_sent, results_seen);
    if (errors == 0) $display("lca_binary_lifting_tb: PASS");
    else $display("lca_binary_lifting_tb: FAIL");
    $finish;
  end

  initial begin
    #50ms;
    $display("lca_binary_lifting_tb: FAIL");
    $finish;
  end

endmodule
